### hw/rtl/pti_pkg.sv
package pti_pkg;

  // table geometry
  localparam int MAX_MODELS = 8;
  localparam int MAX_POINTS = 512;
  localparam int KINDS      = 3;
  localparam int DEPTH      = MAX_MODELS * KINDS * MAX_POINTS;

  // angle arithmetic, 1/64 degree units
  localparam int FULL_TURN  = 23040;
  localparam int TURN_HI    = FULL_TURN / 512;   // 45, turn = 45 * 2^9
  localparam int ANG_OFFSET = FULL_TURN * 365;   // lifts any 24-bit angle above zero
  localparam int MOD_MUL    = 46604;             // ceil(2^21 / 45)
  localparam int MOD_SHR    = 21;

  // derived widths
  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int N_W    = $clog2(MAX_POINTS + 1);
  localparam int MDL_W  = $clog2(MAX_MODELS + 1);
  localparam int ROW_W  = $clog2(MAX_MODELS * KINDS);
  localparam int AW     = $clog2(DEPTH);
  localparam int MAXA_W = PT_W + 15;

  // codes
  localparam logic       FUNC_WRITE = 1'b0;
  localparam logic [1:0] KIND_BAD   = 2'd3;
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_STEP   = 2'd1;
  localparam logic [1:0] CFG_POINTS = 2'd2;
  localparam logic [1:0] CFG_MODELS = 2'd3;

  typedef enum logic [1:0] {
    ST_OK,
    ST_MODEL,
    ST_KIND,
    ST_EMPTY
  } status_e;

  // configuration as seen by the datapath (clamped and precomputed)
  typedef struct packed {
    logic [14:0]       start;
    logic [14:0]       step;
    logic [N_W-1:0]    n;
    logic [MDL_W-1:0]  models;
    logic [MAXA_W-1:0] maxa;
  } cfg_t;

  // classified request, front to back
  typedef struct packed {
    logic             query;
    logic             wen;
    status_e          st;
    logic [ROW_W-1:0] row;
    logic [PT_W-1:0]  pt;
    logic [31:0]      wd;
    logic [14:0]      ang;
  } qent_t;

endpackage

### hw/rtl/pti_front.sv
module pti_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pti_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [2:0]          model_index_i,
  input  logic [1:0]          coef_kind_i,
  input  logic [8:0]          point_index_i,
  input  logic signed [31:0]  point_value_i,
  input  logic signed [23:0]  query_angle_i,
  input  logic                full_i,
  output logic                push_o,
  output pti_pkg::qent_t      ent_o
);
  import pti_pkg::*;

  logic v1_q, v2_q;
  logic rdy1, rdy2;

  // stage 1: captured request
  logic               f1_q;
  logic [2:0]         m1_q;
  logic [1:0]         k1_q;
  logic [8:0]         p1_q;
  logic [31:0]        d1_q;
  logic signed [23:0] a1_q;

  // stage 2: classified, angle split
  logic             q2_q, wen2_q;
  status_e          st2_q;
  logic [ROW_W-1:0] row2_q;
  logic [PT_W-1:0]  pt2_q;
  logic [31:0]      wd2_q;
  logic [15:0]      h2_q;
  logic [10:0]      qt2_q;
  logic [8:0]       lo2_q;

  logic [24:0] xoff;
  logic [15:0] hi;
  logic [31:0] prod;
  status_e     st;
  logic        wen;
  logic [5:0]  r45;

  assign rdy2       = !v2_q || !full_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign push_o     = v2_q && !full_i;

  // offset angle, split into 45 * 2^9 turn parts, quotient by reciprocal
  always_comb begin
    xoff = 25'(int'(a1_q) + ANG_OFFSET);
    hi   = xoff[24:9];
    prod = 32'(32'(hi) * MOD_MUL);
    st   = ST_OK;
    if (32'(m1_q) >= 32'(cfg_i.models)) begin
      st = ST_MODEL;
    end else if (k1_q == KIND_BAD) begin
      st = ST_KIND;
    end else if (cfg_i.n == '0) begin
      st = ST_EMPTY;
    end
    wen = (f1_q == FUNC_WRITE) && (k1_q != KIND_BAD) &&
          (32'(m1_q) < MAX_MODELS) && (32'(p1_q) < MAX_POINTS);
  end

  // remainder by 45 gives the wrapped angle
  always_comb begin
    r45       = 6'(32'(h2_q) - 32'(qt2_q) * TURN_HI);
    ent_o.query = q2_q;
    ent_o.wen   = wen2_q;
    ent_o.st    = st2_q;
    ent_o.row   = row2_q;
    ent_o.pt    = pt2_q;
    ent_o.wd    = wd2_q;
    ent_o.ang   = 15'(32'(r45) * 512 + 32'(lo2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      f1_q <= func_i;
      m1_q <= model_index_i;
      k1_q <= coef_kind_i;
      p1_q <= point_index_i;
      d1_q <= point_value_i;
      a1_q <= query_angle_i;
    end
    if (v1_q && rdy2) begin
      q2_q   <= (f1_q != FUNC_WRITE);
      wen2_q <= wen;
      st2_q  <= st;
      row2_q <= ROW_W'(32'(m1_q) * KINDS + 32'(k1_q));
      pt2_q  <= PT_W'(p1_q);
      wd2_q  <= d1_q;
      h2_q   <= hi;
      qt2_q  <= prod[MOD_SHR+10:MOD_SHR];
      lo2_q  <= xoff[8:0];
    end
  end

endmodule

### hw/rtl/pti_queue.sv
module pti_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pti_pkg::qent_t ent_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output pti_pkg::qent_t head_o
);
  import pti_pkg::*;

  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  qent_t         mem_q [QD];
  logic [QA-1:0] wp_q, rp_q;
  logic [QA:0]   cnt_q;

  assign full_o  = (32'(cnt_q) == QD);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QA+1)'(push_i) - (QA+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= ent_i;
  end

endmodule

### hw/rtl/pti_back.sv
module pti_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pti_pkg::cfg_t       cfg_i,
  input  logic                qv_i,
  input  pti_pkg::qent_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  coef_value_o,
  output logic [1:0]          status_o
);
  import pti_pkg::*;

  localparam int D1 = 15;   // index divider stages
  localparam int D2 = 33;   // rounding divider stages

  typedef struct packed {
    logic             query;
    logic             wen;
    status_e          st;
    logic [ROW_W-1:0] row;
    logic [PT_W-1:0]  pt;
    logic [31:0]      wd;
    logic [14:0]      ang;
    logic             below;
    logic             wrap;
  } ctx_t;

  logic en;

  // index divider pipeline
  logic        v1_q  [0:D1];
  ctx_t        c1_q  [0:D1];
  logic [14:0] r1_q  [0:D1];
  logic [14:0] dq1_q [0:D1];
  logic [14:0] r1_d  [1:D1];
  logic [14:0] dq1_d [1:D1];

  // table memory and read stage
  logic [31:0] mem_q [DEPTH];
  logic [PT_W-1:0] idx0, idx1;
  logic [14:0] num, den;
  logic [AW-1:0] ra0, ra1, wa;
  logic        vE_q;
  status_e     stE_q;
  logic [14:0] numE_q, denE_q;
  logic [31:0] rd0_q, rd1_q;

  // difference, product
  logic               vG_q, vH_q;
  status_e            stG_q, stH_q;
  logic signed [32:0] diffG_q;
  logic [14:0]        numG_q, denG_q, denH_q;
  logic signed [31:0] y0G_q, y0H_q;
  logic signed [48:0] prodH_q;
  logic signed [50:0] nsum;
  logic signed [50:0] nmag;

  // rounding divider pipeline
  logic               v2_q   [0:D2];
  status_e            st2_q  [0:D2];
  logic               neg2_q [0:D2];
  logic signed [31:0] y02_q  [0:D2];
  logic [16:0]        d2_q   [0:D2];
  logic [15:0]        r2_q   [0:D2];
  logic [32:0]        dq2_q  [0:D2];
  logic [15:0]        r2_d   [1:D2];
  logic [32:0]        dq2_d  [1:D2];

  // result
  logic [33:0] qinc, qres;
  logic [31:0] value;
  logic        out_v_q;
  logic signed [31:0] coef_q;
  status_e     status_q;

  ctx_t        c0;
  logic [14:0] ilast;

  assign en           = !out_v_q || !out_stall_i;
  assign pop_o        = en && qv_i;
  assign out_valid_o  = out_v_q;
  assign coef_value_o = coef_q;
  assign status_o     = status_q;

  // entry stage: position against start and last sample
  always_comb begin
    c0.query = head_i.query;
    c0.wen   = head_i.wen;
    c0.st    = head_i.st;
    c0.row   = head_i.row;
    c0.pt    = head_i.pt;
    c0.wd    = head_i.wd;
    c0.ang   = head_i.ang;
    c0.below = head_i.ang < cfg_i.start;
    c0.wrap  = MAXA_W'(head_i.ang) > cfg_i.maxa;
  end

  // one restoring step per stage, offset / step
  always_comb begin
    logic [15:0] t;
    for (int k = 1; k <= D1; k++) begin
      t = {r1_q[k-1], dq1_q[k-1][14]};
      if (t >= {1'b0, cfg_i.step}) begin
        r1_d[k]  = 15'(t - {1'b0, cfg_i.step});
        dq1_d[k] = {dq1_q[k-1][13:0], 1'b1};
      end else begin
        r1_d[k]  = t[14:0];
        dq1_d[k] = {dq1_q[k-1][13:0], 1'b0};
      end
    end
  end

  // segment select: wrap blend, clamp low, clamp high, or interior
  always_comb begin
    ilast = dq1_q[D1];
    if (c1_q[D1].wrap) begin
      idx0 = PT_W'(32'(cfg_i.n) - 1);
      idx1 = '0;
      num  = 15'(32'(c1_q[D1].ang) - 32'(cfg_i.maxa));
      den  = 15'(FULL_TURN - 32'(cfg_i.maxa));
    end else if (c1_q[D1].below) begin
      idx0 = '0;
      idx1 = '0;
      num  = '0;
      den  = cfg_i.step;
    end else if (32'(ilast) >= 32'(cfg_i.n) - 1) begin
      idx0 = PT_W'(32'(cfg_i.n) - 1);
      idx1 = idx0;
      num  = '0;
      den  = cfg_i.step;
    end else begin
      idx0 = PT_W'(ilast);
      idx1 = PT_W'(32'(ilast) + 1);
      num  = r1_q[D1];
      den  = cfg_i.step;
    end
    if (c1_q[D1].st == ST_OK) begin
      ra0 = AW'(32'(c1_q[D1].row) * MAX_POINTS + 32'(idx0));
      ra1 = AW'(32'(c1_q[D1].row) * MAX_POINTS + 32'(idx1));
    end else begin
      ra0 = '0;
      ra1 = '0;
    end
    wa = AW'(32'(c1_q[D1].row) * MAX_POINTS + 32'(c1_q[D1].pt));
  end

  // numerator 2p + den, sign and magnitude
  always_comb begin
    nsum = (51'(prodH_q) <<< 1) + 51'(denH_q);
    nmag = nsum[50] ? -nsum : nsum;
  end

  // one restoring step per stage, |2p + den| / 2den
  always_comb begin
    logic [16:0] t;
    for (int k = 1; k <= D2; k++) begin
      t = {r2_q[k-1], dq2_q[k-1][32]};
      if (t >= d2_q[k-1]) begin
        r2_d[k]  = 16'(t - d2_q[k-1]);
        dq2_d[k] = {dq2_q[k-1][31:0], 1'b1};
      end else begin
        r2_d[k]  = t[15:0];
        dq2_d[k] = {dq2_q[k-1][31:0], 1'b0};
      end
    end
  end

  // floor correction for negative numerators, then add base point
  always_comb begin
    qinc  = 34'(dq2_q[D2]) + 34'(neg2_q[D2] && (r2_q[D2] != '0));
    qres  = neg2_q[D2] ? -qinc : qinc;
    value = 32'(y02_q[D2]) + qres[31:0];
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= D1; k++) v1_q[k] <= 1'b0;
      for (int k = 0; k <= D2; k++) v2_q[k] <= 1'b0;
      vE_q    <= 1'b0;
      vG_q    <= 1'b0;
      vH_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q[0] <= qv_i;
      for (int k = 1; k <= D1; k++) v1_q[k] <= v1_q[k-1];
      vE_q    <= v1_q[D1] && c1_q[D1].query;
      vG_q    <= vE_q;
      vH_q    <= vG_q;
      v2_q[0] <= vH_q;
      for (int k = 1; k <= D2; k++) v2_q[k] <= v2_q[k-1];
      out_v_q <= v2_q[D2];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q[0]  <= c0;
      r1_q[0]  <= '0;
      dq1_q[0] <= head_i.ang - cfg_i.start;
      for (int k = 1; k <= D1; k++) begin
        c1_q[k]  <= c1_q[k-1];
        r1_q[k]  <= r1_d[k];
        dq1_q[k] <= dq1_d[k];
      end
      stE_q   <= c1_q[D1].st;
      numE_q  <= num;
      denE_q  <= den;
      stG_q   <= stE_q;
      diffG_q <= 33'(signed'(rd1_q)) - 33'(signed'(rd0_q));
      y0G_q   <= rd0_q;
      numG_q  <= numE_q;
      denG_q  <= denE_q;
      stH_q   <= stG_q;
      prodH_q <= 49'(diffG_q) * 49'(signed'({1'b0, numG_q}));
      y0H_q   <= y0G_q;
      denH_q  <= denG_q;
      st2_q[0]  <= stH_q;
      neg2_q[0] <= nsum[50];
      y02_q[0]  <= y0H_q;
      d2_q[0]   <= {1'b0, denH_q, 1'b0};
      r2_q[0]   <= nmag[48:33];
      dq2_q[0]  <= nmag[32:0];
      for (int k = 1; k <= D2; k++) begin
        st2_q[k]  <= st2_q[k-1];
        neg2_q[k] <= neg2_q[k-1];
        y02_q[k]  <= y02_q[k-1];
        d2_q[k]   <= d2_q[k-1];
        r2_q[k]   <= r2_d[k];
        dq2_q[k]  <= dq2_d[k];
      end
      if (v2_q[D2]) begin
        coef_q   <= (st2_q[D2] == ST_OK) ? signed'(value) : '0;
        status_q <= st2_q[D2];
      end
    end
  end

  // curve store: point writes and both segment reads at the same stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (v1_q[D1] && c1_q[D1].wen) mem_q[wa] <= c1_q[D1].wd;
      rd0_q <= mem_q[ra0];
      rd1_q <= mem_q[ra1];
    end
  end

  a_div1_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q[D1] |-> (r1_q[D1] < cfg_i.step))
    else $error("index divider remainder not below step");

  a_div2_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q[D2] |-> ({1'b0, r2_q[D2]} < d2_q[D2]))
    else $error("rounding divider remainder not below divisor");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (status_q != ST_OK)) |-> (coef_q == '0))
    else $error("error result carries nonzero value");

endmodule

### hw/rtl/periodic_table_interpolator_unit.sv
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
// request   in         in_valid_i / in_stall_o   func, model, kind, point, value, angle
// result    out        out_valid_o / out_stall_i coef_value, status
//
// One request accepted per cycle while in_stall_o is low.
// A query result passes the 15-stage index divider and the 33-stage rounding divider.
// Point writes update the store at the read stage and produce no result.
// A stalled result holds the back pipeline; the 4-entry queue absorbs the front.
// Reset clears control and configuration; the curve store is not cleared.
module periodic_table_interpolator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [2:0]         model_index_i,
  input  logic [1:0]         coef_kind_i,
  input  logic [8:0]         point_index_i,
  input  logic signed [31:0] point_value_i,
  input  logic signed [23:0] query_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] coef_value_o,
  output logic [1:0]         status_o
);
  import pti_pkg::*;

  logic [14:0] start_q, step_q;
  logic [9:0]  points_q;
  logic [3:0]  models_q;
  cfg_t        cfg_q, cfg_d;

  logic  push, pop, full, empty;
  qent_t ent, head;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      step_q   <= 15'd320;
      points_q <= '0;
      models_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_START:  start_q  <= cfg_wdata_i;
        CFG_STEP:   step_q   <= cfg_wdata_i;
        CFG_POINTS: points_q <= cfg_wdata_i[9:0];
        CFG_MODELS: models_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // clamped view and last sample angle
  always_comb begin
    cfg_d.start  = start_q;
    cfg_d.step   = (step_q == '0) ? 15'd1 : step_q;
    cfg_d.n      = (32'(points_q) > MAX_POINTS) ? N_W'(MAX_POINTS) : N_W'(points_q);
    cfg_d.models = (32'(models_q) > MAX_MODELS) ? MDL_W'(MAX_MODELS) : MDL_W'(models_q);
    cfg_d.maxa   = MAXA_W'((32'(cfg_d.n) - 1) * 32'(cfg_d.step));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start: '0, step: 15'd320, n: '0, models: '0, maxa: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pti_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .model_index_i (model_index_i),
    .coef_kind_i   (coef_kind_i),
    .point_index_i (point_index_i),
    .point_value_i (point_value_i),
    .query_angle_i (query_angle_i),
    .full_i        (full),
    .push_o        (push),
    .ent_o         (ent)
  );

  pti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  pti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .qv_i         (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .coef_value_o (coef_value_o),
    .status_o     (status_o)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pti_pkg::*;

  localparam logic    FUNC_QUERY = ~FUNC_WRITE;
  localparam int      LIMIT      = 600000;
  localparam int      SETTLE     = 100;

  typedef struct {
    logic signed [31:0] value;
    status_e            st;
  } coef_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_addr_i;
  logic [14:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  logic [2:0]         model_index_i;
  logic [1:0]         coef_kind_i;
  logic [8:0]         point_index_i;
  logic signed [31:0] point_value_i;
  logic signed [23:0] query_angle_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] coef_value_o;
  logic [1:0]         status_o;

  periodic_table_interpolator_unit u_dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the table and registers
  logic [31:0]  curve_copy [0:DEPTH-1];
  bit           loaded [0:DEPTH-1];
  logic [14:0]  sh_start, sh_step;
  logic [9:0]   sh_points;
  logic [3:0]   sh_models;
  coef_result_t results_due [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  n_queries = 0;
  int  n_writes = 0;
  int  n_results = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_div(longint p, longint d);
    return fdiv(p * 2 + d, d * 2);
  endfunction

  function automatic longint pt_val(int base, int idx);
    return longint'($signed(curve_copy[base + idx]));
  endfunction

  // interpolated coefficient for one query
  function automatic coef_result_t interpolate(logic [2:0] mdl, logic [1:0] kind,
                                               logic signed [23:0] qa);
    coef_result_t res;
    int     models, n, base;
    longint stp, ang, maxa, d, i, r, y0, y1;
    models = (sh_models > MAX_MODELS) ? MAX_MODELS : sh_models;
    n      = (sh_points > MAX_POINTS) ? MAX_POINTS : sh_points;
    res.value = 0;
    res.st    = ST_OK;
    if (mdl >= models) res.st = ST_MODEL;
    else if (kind == KIND_BAD) res.st = ST_KIND;
    else if (n == 0) res.st = ST_EMPTY;
    else begin
      base = (mdl * KINDS + kind) * MAX_POINTS;
      stp  = (sh_step == 0) ? 1 : sh_step;
      ang  = longint'(qa) % FULL_TURN;
      if (ang < 0) ang += FULL_TURN;
      maxa = longint'(n - 1) * stp;
      if (ang <= maxa) begin
        d = ang - sh_start;
        if (d < 0) res.value = pt_val(base, 0);
        else begin
          i = d / stp;
          r = d % stp;
          if (i >= n - 1) res.value = pt_val(base, n - 1);
          else begin
            y0 = pt_val(base, i);
            y1 = pt_val(base, i + 1);
            res.value = y0 + round_div((y1 - y0) * r, stp);
          end
        end
      end else begin
        y0 = pt_val(base, n - 1);
        y1 = pt_val(base, 0);
        res.value = y0 + round_div((y1 - y0) * (ang - maxa), FULL_TURN - maxa);
      end
    end
    return res;
  endfunction

  // curve points a query reads, -1 where none
  function automatic void read_set(logic [2:0] mdl, logic [1:0] kind,
                                   logic signed [23:0] qa, output int p0, output int p1);
    int     models, n;
    longint stp, ang, maxa, d, i;
    p0 = -1;
    p1 = -1;
    models = (sh_models > MAX_MODELS) ? MAX_MODELS : sh_models;
    n      = (sh_points > MAX_POINTS) ? MAX_POINTS : sh_points;
    if (mdl < models && kind != KIND_BAD && n != 0) begin
      stp  = (sh_step == 0) ? 1 : sh_step;
      ang  = longint'(qa) % FULL_TURN;
      if (ang < 0) ang += FULL_TURN;
      maxa = longint'(n - 1) * stp;
      if (ang <= maxa) begin
        d = ang - sh_start;
        if (d < 0) p0 = 0;
        else begin
          i = d / stp;
          if (i >= n - 1) p0 = n - 1;
          else begin
            p0 = int'(i);
            p1 = int'(i) + 1;
          end
        end
      end else begin
        p0 = n - 1;
        p1 = 0;
      end
    end
  endfunction

  // send one request and record what it should produce
  task automatic send_req(logic fn, logic [2:0] mdl, logic [1:0] kind, logic [8:0] pt,
                          logic signed [31:0] val, logic signed [23:0] qa);
    int gap;
    int idx;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    model_index_i <= mdl;
    coef_kind_i   <= kind;
    point_index_i <= pt;
    point_value_i <= val;
    query_angle_i <= qa;
    do @(posedge clk_i); while (in_stall_o);
    if (fn == FUNC_WRITE) begin
      n_writes++;
      if (kind != KIND_BAD) begin
        idx = (mdl * KINDS + kind) * MAX_POINTS + pt;
        curve_copy[idx] = val;
        loaded[idx]     = 1'b1;
      end
    end else begin
      n_queries++;
      results_due.insert(results_due.size(), interpolate(mdl, kind, qa));
    end
  endtask

  task automatic put_point(logic [2:0] mdl, logic [1:0] kind, logic [8:0] pt,
                           logic signed [31:0] val);
    send_req(FUNC_WRITE, mdl, kind, pt, val, 24'($urandom));
  endtask

  // points the query reads get a value first if they have none yet
  task automatic query(logic [2:0] mdl, logic [1:0] kind, logic signed [23:0] qa);
    int p0, p1, row;
    read_set(mdl, kind, qa, p0, p1);
    row = (mdl * KINDS + kind) * MAX_POINTS;
    if (p0 >= 0 && !loaded[row + p0]) put_point(mdl, kind, 9'(p0), $urandom);
    if (p1 >= 0 && !loaded[row + p1]) put_point(mdl, kind, 9'(p1), $urandom);
    send_req(FUNC_QUERY, mdl, kind, '0, $urandom, qa);
  endtask

  // wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // idle the block, then write one register
  task automatic set_reg(logic [1:0] idx, logic [14:0] val);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START:  sh_start  = val;
      CFG_STEP:   sh_step   = val;
      CFG_POINTS: sh_points = val[9:0];
      CFG_MODELS: sh_models = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [14:0] st, logic [14:0] sp, logic [14:0] np,
                         logic [14:0] nm);
    set_reg(CFG_START, st);
    set_reg(CFG_STEP, sp);
    set_reg(CFG_POINTS, np);
    set_reg(CFG_MODELS, nm);
  endtask

  // error codes and their priority
  task automatic test_errors();
    query(0, 0, 0);
    query(7, KIND_BAD, 100);
    set_all(0, 320, 0, 15);
    query(7, KIND_BAD, 0);
    query(3, 1, 500);
    set_reg(CFG_MODELS, 2);
    query(2, 0, 0);
    query(1, KIND_BAD, 0);
  endtask

  // end values, angle extremes, wrap segment, clamps
  task automatic test_edges();
    set_all(0, 45, 512, 8);
    put_point(0, 0, 0, 32'sh8000_0000);
    put_point(0, 0, 1, 32'sh7FFF_FFFF);
    put_point(0, 0, 511, 32'sh7FFF_FFFF);
    put_point(0, KIND_BAD, 0, 32'sh1234_5678);
    query(0, 0, 24'sh800000);
    query(0, 0, 24'sh7FFFFF);
    query(0, 0, 22);
    query(0, 0, 23);
    query(0, 0, 22995);
    query(0, 0, 23039);
    query(0, 0, -1);
    query(0, 2, -23040);
    set_all(1000, 0, 1023, 8);
    query(7, 2, 999);
    query(7, 2, 1500);
    query(7, 2, 23039);
    set_all(32767, 32767, 2, 8);
    query(5, 1, 23000);
    set_all(0, 100, 10, 8);
    query(4, 0, 900);
    query(4, 0, 901);
    set_all(0, 23040, 1, 8);
    query(6, 1, 5);
  endtask

  // random configurations with mostly well-formed queries
  task automatic test_random();
    int models;
    int pick;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) set_all(23039, 1, 512, 8);
      else if (ph == 1) set_all(0, 32767, 3, 1);
      else begin
        set_all(15'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(0, 23039)),
                15'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(1, 400)),
                15'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(2, 512)),
                15'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 8));
      end
      quiet = (ph == 3);
      models = (sh_models > MAX_MODELS) ? MAX_MODELS : sh_models;
      for (int it = 0; it < 24; it++) begin
        if (ph == 5 && it == 12) drain();
        pick = $urandom_range(0, 99);
        if (pick < 82 && models > 0)
          query(3'($urandom_range(0, models - 1)), 2'($urandom_range(0, 2)),
                $urandom_range(0, 1) ? $signed(24'($urandom))
                                     : $signed(24'($urandom_range(0, FULL_TURN - 1))));
        else if (pick < 94)
          put_point(3'($urandom), 2'($urandom), 9'($urandom), $urandom);
        else
          query(3'($urandom), 2'($urandom), 24'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // result side: random stalls, compare against oldest expectation
  always @(posedge clk_i) begin
    coef_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      stall_left = draw_wait();
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%0d status=%0d", coef_value_o, status_o);
      end else begin
        want = results_due.pop_front();
        if (coef_value_o !== want.value || status_o !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     want.value, want.st, coef_value_o, status_o);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    func_i        <= FUNC_WRITE;
    model_index_i <= '0;
    coef_kind_i   <= '0;
    point_index_i <= '0;
    point_value_i <= '0;
    query_angle_i <= '0;
    out_stall_i   <= 1'b0;
    sh_start  = 0;
    sh_step   = 320;
    sh_points = 0;
    sh_models = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_errors();
    test_edges();
    test_random();

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d queries and %0d point writes over 10 random settings,",
             n_queries, n_writes);
    $display("%0d results checked, %0d mismatches", n_results, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pti_pkg.sv
hw/rtl/pti_front.sv
hw/rtl/pti_queue.sv
hw/rtl/pti_back.sv
hw/rtl/periodic_table_interpolator_unit.sv
tb/sv/tb.sv
